/* sv/lsdk_pkg.sv */
// Package for the longest divisible-sum subarray block.
// Holds widths, limits, payload structs, the remainder unit's interface
// and the state machine types. No dependencies.
package lsdk_pkg;

    // Element and modulus widths
    localparam int ELEM_W = 32;
    localparam int SUM_W  = ELEM_W + 2;
    localparam int CNT_W  = $clog2(ELEM_W);
    localparam int MAX_K  = 1024;
    localparam int K_W    = $clog2(MAX_K) + 1;
    localparam int REM_W  = $clog2(MAX_K);

    // Sequence length limits
    localparam int MAX_LEN = 65536;
    localparam int LEN_W   = $clog2(MAX_LEN) + 1;
    localparam int POS_W   = $clog2(MAX_LEN);

    // First-seen table entry tag; tag 0 marks an entry as never written
    localparam int EPOCH_W = 8;

    // Input transfer payload
    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic                     last_element;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic [POS_W-1:0] position;
        logic             too_long;
        logic             end_of_sequence;
    } t_out_item;

    // Request into the serial remainder unit
    typedef struct packed {
        logic              start;
        logic [ELEM_W-1:0] magnitude;
        logic              negative;
        logic [K_W-1:0]    k;
    } t_rem_req;

    // Status back from the serial remainder unit
    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] residue;
    } t_rem_status;

    // Remainder unit sequencer
    typedef enum logic [1:0] {
        REM_IDLE,
        REM_SHIFT,
        REM_FIX
    } t_rem_state;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_LOOK,
        ST_DONE,
        ST_CLEAR
    } t_state;

endpackage

/* sv/lsdk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsdk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lsdk_rem_unit.sv */
// Bit-serial remainder unit: magnitude mod k one bit per cycle, then a
// sign fix that maps a negative value's remainder into 0..k-1.
// Depends on lsdk_pkg.
module lsdk_rem_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsdk_pkg::t_rem_req   i_req,
    output lsdk_pkg::t_rem_status o_status
);
    import lsdk_pkg::*;

    t_rem_state        r_state, n_state;
    logic [ELEM_W-1:0] r_dvd, n_dvd;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [K_W-1:0]    r_k, n_k;

    // Shared subtract/compare unit
    logic [K_W-1:0] sub_a, sub_b, sub_diff;
    logic           sub_ge;
    logic [K_W-1:0] rem_sh;

    assign rem_sh   = {r_rem, r_dvd[ELEM_W-1]};
    assign sub_diff = sub_a - sub_b;
    assign sub_ge   = (sub_a >= sub_b);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            REM_IDLE:  if (i_req.start) n_state = REM_SHIFT;
            REM_SHIFT: if (r_cnt == CNT_W'(ELEM_W - 1)) n_state = REM_FIX;
            REM_FIX:   n_state = REM_IDLE;
            default:   n_state = REM_IDLE;
        endcase
    end

    // Datapath control and outputs
    always_comb begin
        sub_a            = rem_sh;
        sub_b            = r_k;
        n_dvd            = r_dvd;
        n_rem            = r_rem;
        n_cnt            = r_cnt;
        n_neg            = r_neg;
        n_k              = r_k;
        o_status.done    = 1'b0;
        o_status.residue = r_rem;
        case (r_state)
            REM_IDLE: begin
                if (i_req.start) begin
                    n_dvd = i_req.magnitude;
                    n_rem = '0;
                    n_cnt = '0;
                    n_neg = i_req.negative;
                    n_k   = i_req.k;
                end
            end
            REM_SHIFT: begin
                // restoring step: shift in next bit, subtract k when it fits
                n_dvd = {r_dvd[ELEM_W-2:0], 1'b0};
                n_rem = sub_ge ? sub_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                n_cnt = r_cnt + 1'b1;
            end
            REM_FIX: begin
                // negative value: k - rem unless rem is zero
                sub_a         = r_k;
                sub_b         = {1'b0, r_rem};
                o_status.done = 1'b1;
                if (r_neg && (r_rem != '0)) begin
                    o_status.residue = sub_diff[REM_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= REM_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_k   <= n_k;
    end

endmodule

/* sv/longest_subarray_sum_divisible.sv */
// Top level: longest subarray with sum divisible by k, as a stream.
// Depends on lsdk_pkg, lsdk_rem_unit and lsdk_ram.
//
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// output   out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config   in         i_cfg_we                  i_cfg_wdata (modulus)
//
// An element passes through the bit-serial remainder unit over its 32
// magnitude bits, then the sign fix, the table read and the commit.
// The input opens again in the cycle after the result is loaded, so an
// element is taken only once the last one is through. An element beyond
// the length limit skips the remainder unit and goes straight to commit.
// Reset is synchronous, active low. After reset, and after every 255th
// sequence, a clearing pass over all 1024 entries empties the first-seen
// table while the input stalls; in between, entries carry a per-sequence
// epoch tag. A stalled output holds its result; the next element may already
// be accepted and waits in the commit step until the output register frees.
module longest_subarray_sum_divisible (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lsdk_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lsdk_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [lsdk_pkg::K_W-1:0] i_cfg_wdata
);
    import lsdk_pkg::*;

    t_state            r_state, n_state;
    logic [K_W-1:0]    r_modulus;
    logic [REM_W-1:0]  r_run, n_run;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  r_longest, n_longest;
    logic [EPOCH_W-1:0] r_epoch;
    logic [REM_W-1:0]  r_clr_addr;
    logic [REM_W-1:0]  r_rem_new;
    logic              r_last;
    logic              r_too_long;
    logic              r_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic              accept;
    logic              commit;
    logic              clearing;
    logic              epoch_wrap;
    logic              out_free;
    logic              too_long_now;
    logic [K_W-1:0]    eff_k;
    logic [SUM_W-1:0]  sum, sum_abs;
    t_rem_req          rem_req;
    t_rem_status       rem_status;
    logic              ram_we;
    logic [REM_W-1:0]  ram_waddr;
    logic [EPOCH_W+POS_W-1:0] ram_wdata, ram_rdata;
    logic [EPOCH_W-1:0] rd_epoch;
    logic              seen_hit;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  cur_pos;
    logic [LEN_W-1:0]  span;
    logic              set_bit;

    // Effective modulus: zero acts as 1, above the table size clamps
    always_comb begin
        eff_k = r_modulus;
        if (r_modulus == '0) begin
            eff_k = K_W'(1);
        end else if (r_modulus > K_W'(MAX_K)) begin
            eff_k = K_W'(MAX_K);
        end
    end

    // Running remainder plus element, then magnitude and sign
    assign sum     = {{2{i_in_data.element_value[ELEM_W-1]}}, i_in_data.element_value}
                   + {{(SUM_W-REM_W){1'b0}}, r_run};
    assign sum_abs = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

    assign too_long_now = (r_count >= LEN_W'(MAX_LEN));
    assign out_free     = !r_out_valid || !i_out_stall;
    assign epoch_wrap   = (r_epoch == '1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = too_long_now ? ST_DONE : ST_CALC;
            ST_CALC: if (rem_status.done) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = (r_last && epoch_wrap) ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: if (r_clr_addr == REM_W'(MAX_K - 1)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        commit     = 1'b0;
        clearing   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
            end
            ST_DONE:  commit = out_free;
            ST_CLEAR: clearing = 1'b1;
            default: begin
            end
        endcase
    end

    assign rem_req.start     = accept && !too_long_now;
    assign rem_req.magnitude = sum_abs[ELEM_W-1:0];
    assign rem_req.negative  = sum[SUM_W-1];
    assign rem_req.k         = eff_k;

    lsdk_rem_unit u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (rem_req),
        .o_status (rem_status)
    );

    // First-seen position table; an entry counts only under the current epoch
    assign cur_pos   = r_count[POS_W-1:0];
    assign set_bit   = commit && !r_too_long && (r_rem_new != '0) && !seen_hit;
    assign ram_we    = set_bit || clearing;
    assign ram_waddr = clearing ? r_clr_addr : r_rem_new;
    assign ram_wdata = clearing ? '0 : {r_epoch, cur_pos};

    lsdk_ram #(
        .WIDTH (EPOCH_W + POS_W),
        .DEPTH (MAX_K)
    ) u_first_pos (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rem_new),
        .o_rdata (ram_rdata)
    );

    assign {rd_epoch, first_pos} = ram_rdata;
    assign seen_hit              = (rd_epoch == r_epoch);

    // Commit: new longest run, counters and the result
    assign span = {1'b0, cur_pos} - {1'b0, first_pos};

    always_comb begin
        n_longest = r_longest;
        n_run     = r_run;
        n_count   = r_count;
        if (!r_too_long) begin
            n_run   = r_rem_new;
            n_count = r_count + 1'b1;
            if (r_rem_new == '0) begin
                n_longest = r_count + 1'b1;
            end else if (seen_hit && (cur_pos >= first_pos) && (span > r_longest)) begin
                n_longest = span;
            end
        end
        n_out_data.best_length     = n_longest;
        n_out_data.position        = r_too_long ? '0 : cur_pos;
        n_out_data.too_long        = r_too_long;
        n_out_data.end_of_sequence = r_last;
    end

    // Sequencer and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_modulus   <= K_W'(1);
            r_run       <= '0;
            r_count     <= '0;
            r_longest   <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (commit) begin
                if (r_last) begin
                    // a new epoch retires every entry of the ended sequence
                    r_run     <= '0;
                    r_count   <= '0;
                    r_longest <= '0;
                    r_epoch   <= epoch_wrap ? EPOCH_W'(1) : r_epoch + 1'b1;
                end else begin
                    r_run     <= n_run;
                    r_count   <= n_count;
                    r_longest <= n_longest;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-element payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last     <= i_in_data.last_element;
            r_too_long <= too_long_now;
        end
        if (rem_status.done) begin
            r_rem_new <= rem_status.residue;
        end
        if (commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* sv/lsdk_checker.sv */
// Port-level checker for the longest divisible-sum subarray block,
// bound to the top level. Depends on lsdk_pkg.
module lsdk_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lsdk_pkg::t_out_item o_out_data
);
    import lsdk_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // The block is busy right after taking an element
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // An ignored element reports position zero
    a_too_long_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.too_long |-> o_out_data.position == '0)
        else $error("ignored element with nonzero position");

    // The best run never exceeds the elements seen so far
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.too_long |->
        o_out_data.best_length <= ({1'b0, o_out_data.position} + LEN_W'(1)))
        else $error("best length exceeds position plus one");

endmodule

bind longest_subarray_sum_divisible lsdk_checker u_lsdk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* verif/longest_subarray_sum_divisible_test.sv */
// Self-checking testbench for longest_subarray_sum_divisible: random sequences, modulus
// changes and idle/stall gaps, with an in-bench predictor of the longest divisible run.
// Depends on lsdk_pkg and the longest_subarray_sum_divisible RTL.
`timescale 1ns / 100ps

module longest_subarray_sum_divisible_test;
    import lsdk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_TARGET  = 1944;

    // Predicts one result per accepted element and checks results in order
    class subarray_tracker;
        logic [K_W-1:0] modulus;
        int unsigned    remainder;
        int unsigned    count;
        int unsigned    longest;
        int unsigned    errors;
        bit             seen [MAX_K];
        int unsigned    first_pos [MAX_K];
        t_out_item      expected_results [$];

        function new();
            modulus = 1;
            errors  = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            remainder = 0;
            count     = 0;
            longest   = 0;
            foreach (seen[n]) seen[n] = 1'b0;
        endfunction

        function void set_modulus(logic [K_W-1:0] value);
            modulus = value;
        endfunction

        // Zero acts as one, anything past the table size is clamped
        function int unsigned effective_k();
            if (modulus == 0) return 1;
            if (modulus > MAX_K) return MAX_K;
            return modulus;
        endfunction

        // Mathematical residue of a signed element, in 0..k-1
        function int unsigned residue_of(logic signed [ELEM_W-1:0] value, int unsigned k);
            longint wide;
            longint kk;
            wide = value;
            kk   = k;
            wide = wide % kk;
            if (wide < 0) wide += kk;
            return int'(wide);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_element(t_in_item item);
            t_out_item   res;
            int unsigned k;
            int unsigned r;
            res = '0;
            res.end_of_sequence = item.last_element;
            if (count >= MAX_LEN) begin
                // past the length limit: ignored, position reads zero
                res.too_long = 1'b1;
            end else begin
                k = effective_k();
                r = ((remainder % k) + residue_of(item.element_value, k)) % k;
                remainder    = r;
                res.position = POS_W'(count);
                if (r == 0) begin
                    longest = count + 1;
                end else if (seen[r]) begin
                    if (count >= first_pos[r] && count - first_pos[r] > longest)
                        longest = count - first_pos[r];
                end else begin
                    seen[r]      = 1'b1;
                    first_pos[r] = count & 32'hFFFF;
                end
                count++;
            end
            res.best_length = LEN_W'(longest);
            expected_results.push_back(res);
            if (item.last_element) clear_sequence();
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: expected none, actual %p",
                         $time, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.best_length != want.best_length)
                flag("best_length", want.best_length, got.best_length);
            if (got.position != want.position)
                flag("position", want.position, got.position);
            if (got.too_long != want.too_long)
                flag("too_long", want.too_long, got.too_long);
            if (got.end_of_sequence != want.end_of_sequence)
                flag("end_of_sequence", want.end_of_sequence, got.end_of_sequence);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_we = 1'b0;
    logic [K_W-1:0]   i_cfg_wdata = '0;

    subarray_tracker  tracker;
    bit               steady = 1'b0;
    bit               output_free = 1'b0;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int unsigned      elements_sent = 0;

    longest_subarray_sum_divisible u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(4, 1);
        return $urandom_range(60, 15);
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_element(int unsigned k);
        int roll;
        int mult;
        roll = $urandom_range(99);
        if (roll < 40) return $urandom();
        if (roll < 65) return $signed($urandom_range(40)) - 20;
        if (roll < 85) begin
            // multiples of k keep the prefix remainder, so repeats show up
            mult = $urandom_range(8);
            mult = mult * int'(k);
            return ($urandom_range(1) != 0) ? mult : -mult;
        end
        case ($urandom_range(3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [K_W-1:0] pick_modulus();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            case ($urandom_range(8))
                0:       return 0;
                1:       return 1;
                2:       return 2;
                3:       return 3;
                4:       return 7;
                5:       return 1023;
                6:       return 1024;
                7:       return 1025;
                default: return 2047;
            endcase
        end
        if (roll < 70) return $urandom_range(64, 1);
        if (roll < 95) return $urandom_range(1024, 1);
        return $urandom_range(2047, 1025);
    endfunction

    // Drive one element and hold it until the transfer; valid stays up on return
    task automatic send_element(logic signed [ELEM_W-1:0] value, logic last);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{element_value: value, last_element: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        elements_sent++;
    endtask

    task automatic send_sequence(int len, bit close);
        for (int n = 0; n < len; n++)
            send_element(pick_element(tracker.effective_k()), close && (n == len - 1));
    endtask

    // Sender holds off until every pending result has come back
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [K_W-1:0] value);
        drain_outputs();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Output side: random stall runs, or none while output_free is set
    always @(posedge i_clk) begin
        if (!i_rst_n || output_free) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            stall_left = pick_gap(1'b0);
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Transfer monitor, register writes and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_we) begin
                tracker.set_modulus(i_cfg_wdata);
                quiet_cycles = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.note_element(i_in_data);
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                tracker.check_result(o_out_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results pending",
                         $time, quiet_cycles, tracker.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int          nseq;
        int          len;
        bit          close;

        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset modulus of one: every prefix divides, length is position + 1
        send_element(5, 1'b0);
        send_element(-7, 1'b1);

        // Extreme element values, single-element sequence
        write_modulus(7);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(0, 1'b0);
        send_element(-1, 1'b0);
        send_element(3, 1'b1);
        send_element(4, 1'b1);

        // Zero modulus acts as one
        write_modulus(0);
        send_element(12345, 1'b0);
        send_element(-9, 1'b1);

        // Modulus above the table size is clamped
        write_modulus(2047);
        send_element(1023, 1'b0);
        send_element(1, 1'b0);
        send_element(-1024, 1'b0);
        send_element(5, 1'b1);

        // Modulus changed in the middle of a sequence
        write_modulus(1024);
        send_element(1000, 1'b0);
        send_element(3, 1'b0);
        write_modulus(5);
        send_element(2, 1'b0);
        send_element(7, 1'b1);

        // Random phases, each with its own modulus; some leave a sequence open
        while (elements_sent < RANDOM_TARGET) begin
            write_modulus(pick_modulus());
            steady      = ($urandom_range(3) == 0);
            output_free = ($urandom_range(4) == 0);
            nseq = $urandom_range(5, 1);
            for (int s = 0; s < nseq; s++) begin
                if (int'(elements_sent) >= RANDOM_TARGET) break;
                len   = ($urandom_range(9) == 0) ? $urandom_range(200, 41)
                                                 : $urandom_range(40, 1);
                if (len > RANDOM_TARGET - int'(elements_sent))
                    len = RANDOM_TARGET - int'(elements_sent);
                close = (s < nseq - 1) || ($urandom_range(9) >= 3);
                send_sequence(len, close);
                if ($urandom_range(7) == 0) drain_outputs();
            end
        end

        // Closing sequence under random gaps and stalls
        steady      = 1'b0;
        output_free = 1'b0;
        send_sequence(6, 1'b1);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/lsdk_pkg.sv
sv/lsdk_ram.sv
sv/lsdk_rem_unit.sv
sv/longest_subarray_sum_divisible.sv
sv/lsdk_checker.sv
verif/longest_subarray_sum_divisible_test.sv
